[rtl/core/ssvbp_pkg.sv]
// shared types and constants for the swept state-variable band-pass core
// command struct, multiplier operand codes, register indexes and reset values
// no dependencies
package ssvbp_pkg;

    // field and state widths
    localparam int SAMPLE_W   = 16;
    localparam int SEL_W      = 2;
    localparam int FREQ_W     = 15;
    localparam int STEP_W     = 28;
    localparam int DAMP_W     = 15;
    localparam int PPHZ_W     = 24;
    localparam int HZ_FRAC    = 24;
    localparam int CF_W       = 40;
    localparam int ST_W       = 40;
    localparam int WIDE_W     = 44;
    localparam int SINE_W     = 17;
    localparam int F1_W       = 19;
    localparam int PHASE_W    = 32;
    localparam int PHASE_LSB  = 25;
    localparam int DAMP_SHIFT = 15;
    localparam int TUNE_SHIFT = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // split multiplier geometry
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = 25;
    localparam int MUL_SPLIT  = 20;
    localparam int MUL_PART_W = MUL_A_W - MUL_SPLIT + MUL_B_W;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    // output select codes
    localparam logic [SEL_W-1:0] SEL_DRY = 2'd1;
    localparam logic [SEL_W-1:0] SEL_WET = 2'd2;

    // register reset values
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 15'd500;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 15'd3000;
    localparam logic [STEP_W-1:0] STEP_RST     = 28'd699051;
    localparam logic [DAMP_W-1:0] DAMP_RST     = 15'd1638;
    localparam logic [PPHZ_W-1:0] PPHZ_RST     = 24'd89478;
    localparam logic [CF_W-1:0]   CF_RST       = 40'd500 << HZ_FRAC;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FREQ     = 3'd0,
        CFG_MAX_FREQ     = 3'd1,
        CFG_SWEEP_STEP   = 3'd2,
        CFG_DAMPING      = 3'd3,
        CFG_PHASE_PER_HZ = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        MUL_PHASE = 2'd0,
        MUL_DAMP  = 2'd1,
        MUL_BAND  = 2'd2,
        MUL_LOW   = 2'd3
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        mul_sel_t mul_sel;
        logic     phase_load;
        logic     f1_load;
        logic     hp_load;
        logic     band_load;
        logic     low_load;
        logic     out_load;
    } ssvbp_cmd_t;

endpackage

[rtl/core/ssvbp_mul.sv]
// two-stage signed multiplier, wide operand split into two halves
// stage one forms the partial products, stage two recombines them
// depends on ssvbp_pkg
module ssvbp_mul (
    input  logic                                 clk,
    input  logic signed [ssvbp_pkg::MUL_A_W-1:0] a,
    input  logic signed [ssvbp_pkg::MUL_B_W-1:0] b,
    output logic signed [ssvbp_pkg::MUL_P_W-1:0] prod
);
    import ssvbp_pkg::*;

    logic signed [MUL_SPLIT:0]         a_lo;
    logic signed [MUL_A_W-MUL_SPLIT-1:0] a_hi;
    logic signed [MUL_PART_W-1:0]      p_lo_reg;
    logic signed [MUL_PART_W-1:0]      p_hi_reg;
    logic signed [MUL_P_W-1:0]         prod_next;
    logic signed [MUL_P_W-1:0]         prod_reg;

    // low half taken as unsigned, high half keeps the sign
    assign a_lo = $signed({1'b0, a[MUL_SPLIT-1:0]});
    assign a_hi = a[MUL_A_W-1:MUL_SPLIT];

    // partial products
    always_ff @(posedge clk)
    begin
        p_lo_reg <= MUL_PART_W'(a_lo * b);
        p_hi_reg <= MUL_PART_W'(a_hi * b);
    end

    // recombine
    assign prod_next = (MUL_P_W'(p_hi_reg) <<< MUL_SPLIT) + MUL_P_W'(p_lo_reg);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[rtl/core/ssvbp_sine_rom.sv]
// quarter-wave sine table, Q1.16 entries, registered read
// entries are built at elaboration from a truncating Taylor series in Q30
// depends on ssvbp_pkg
module ssvbp_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                            clk,
    input  logic [$clog2(DEPTH + 1)-1:0]    addr,
    output logic [ssvbp_pkg::SINE_W-1:0]    data
);
    import ssvbp_pkg::*;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    logic [SINE_W-1:0] sine_tbl [0:DEPTH];
    logic [SINE_W-1:0] data_reg;

    // sin(x) with x in Q30, seven-term series, rounded to Q16
    function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd8192) >> 14;
        if (s > 64'd65536)
        begin
            s = 64'd65536;
        end
        return s[SINE_W-1:0];
    endfunction

    // table entries, one per quarter-wave step including the end point
    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_entry
        localparam logic [63:0]       XK    = (HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(XK);
        assign sine_tbl[k] = ENTRY;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        data_reg <= sine_tbl[addr];
    end

    assign data = data_reg;

endmodule

[rtl/core/ssvbp_datapath.sv]
// datapath: configuration registers, sweep, tuning lookup and filter state
// driven by the command struct from the controller
// depends on ssvbp_pkg, ssvbp_mul and ssvbp_sine_rom
module ssvbp_datapath #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int STATE_FRAC_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ssvbp_pkg::ssvbp_cmd_t                   cmd,
    input  logic                                    cfg_write,
    input  logic        [ssvbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ssvbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [ssvbp_pkg::SAMPLE_W-1:0]   left_sample,
    input  logic signed [ssvbp_pkg::SAMPLE_W-1:0]   right_sample,
    input  logic        [ssvbp_pkg::SEL_W-1:0]      select,
    output logic signed [ssvbp_pkg::SAMPLE_W-1:0]   out_sample
);
    import ssvbp_pkg::*;

    localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int POS_W      = 31;
    localparam int IDX_PROD_W = POS_W + ADDR_W;

    // configuration
    logic [FREQ_W-1:0] min_freq_reg;
    logic [FREQ_W-1:0] max_freq_reg;
    logic [STEP_W-1:0] sweep_step_reg;
    logic [DAMP_W-1:0] damping_reg;
    logic [PPHZ_W-1:0] phase_per_hz_reg;

    // architectural state
    logic [CF_W-1:0]          cf_reg;
    logic                     sweep_down_reg;
    logic signed [ST_W-1:0]   band_reg;
    logic signed [ST_W-1:0]   low_reg;
    logic signed [SAMPLE_W-1:0] last_reg;

    // per-transaction working registers
    logic signed [SAMPLE_W-1:0] mono_reg;
    logic [SEL_W-1:0]           sel_reg;
    logic                       neg_reg;
    logic signed [F1_W-1:0]     f1_reg;
    logic signed [ST_W-1:0]     hp_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W-1:0] mono_next;
    logic [CF_W-1:0]            hi_bound;
    logic [CF_W-1:0]            lo_bound;
    logic                       above;
    logic                       below;
    logic [CF_W-1:0]            cf_upper;
    logic [CF_W-1:0]            cf_clamped;
    logic                       out_of_range;
    logic [CF_W-1:0]            step_ext;
    logic [CF_W-1:0]            cf_swept;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_prod;
    logic signed [MUL_B_W-1:0]  f1_ext;

    logic [PHASE_W-1:0]         phase;
    logic [POS_W-1:0]           pos_raw;
    logic [POS_W-1:0]           pos;
    logic [IDX_PROD_W-1:0]      idx_prod;
    logic [ADDR_W-1:0]          rom_addr;
    logic [SINE_W-1:0]          rom_data;
    logic signed [F1_W-1:0]     f1_twice;

    logic signed [ST_W-1:0]     x_val;
    logic signed [WIDE_W-1:0]   damp_term;
    logic signed [WIDE_W-1:0]   tune_term;
    logic signed [WIDE_W-1:0]   hp_wide;
    logic signed [WIDE_W-1:0]   band_wide;
    logic signed [WIDE_W-1:0]   low_wide;
    logic signed [ST_W-1:0]     wet_shift;
    logic signed [SAMPLE_W-1:0] wet;
    logic signed [SAMPLE_W-1:0] last_next;

    // saturate a widened sum back to the state width
    function automatic logic signed [ST_W-1:0] sat_state(input logic signed [WIDE_W-1:0] v);
        logic ovf;
        ovf = (v[WIDE_W-1:ST_W-1] != {(WIDE_W - ST_W + 1){v[WIDE_W-1]}});
        return ovf ? {v[WIDE_W-1], {(ST_W - 1){~v[WIDE_W-1]}}} : v[ST_W-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg     <= MIN_FREQ_RST;
            max_freq_reg     <= MAX_FREQ_RST;
            sweep_step_reg   <= STEP_RST;
            damping_reg      <= DAMP_RST;
            phase_per_hz_reg <= PPHZ_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_FREQ:     min_freq_reg     <= cfg_data[FREQ_W-1:0];
                CFG_MAX_FREQ:     max_freq_reg     <= cfg_data[FREQ_W-1:0];
                CFG_SWEEP_STEP:   sweep_step_reg   <= cfg_data[STEP_W-1:0];
                CFG_DAMPING:      damping_reg      <= cfg_data[DAMP_W-1:0];
                CFG_PHASE_PER_HZ: phase_per_hz_reg <= cfg_data[PPHZ_W-1:0];
                default:          ;
            endcase
        end
    end

    // stereo to mono, floor of the half sum
    assign pair_sum  = (SAMPLE_W + 1)'(left_sample) + (SAMPLE_W + 1)'(right_sample);
    assign mono_next = pair_sum[SAMPLE_W:1];

    // sweep bounds in Q15.24
    assign hi_bound = {1'b0, max_freq_reg, {HZ_FRAC{1'b0}}};
    assign lo_bound = {1'b0, min_freq_reg, {HZ_FRAC{1'b0}}};

    // clamp before the sample, upper bound first
    assign above      = cf_reg > hi_bound;
    assign cf_upper   = above ? hi_bound : cf_reg;
    assign below      = cf_upper < lo_bound;
    assign cf_clamped = below ? lo_bound : cf_upper;

    // step after the sample, saturating at zero on the way down
    assign out_of_range = (cf_reg > hi_bound) || (cf_reg < lo_bound);
    assign step_ext     = CF_W'(sweep_step_reg);
    always_comb
    begin
        if (out_of_range)
        begin
            cf_swept = cf_reg;
        end
        else if (sweep_down_reg)
        begin
            cf_swept = (cf_reg > step_ext) ? cf_reg - step_ext : '0;
        end
        else
        begin
            cf_swept = cf_reg + step_ext;
        end
    end

    // multiplier operand selection
    assign f1_ext = MUL_B_W'(f1_reg);
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_PHASE:
            begin
                mul_a = $signed({1'b0, cf_reg});
                mul_b = $signed({1'b0, phase_per_hz_reg});
            end
            MUL_DAMP:
            begin
                mul_a = MUL_A_W'(band_reg);
                mul_b = $signed({{(MUL_B_W - DAMP_W - 1){1'b0}}, damping_reg, 1'b0});
            end
            MUL_BAND:
            begin
                mul_a = MUL_A_W'(hp_reg);
                mul_b = f1_ext;
            end
            MUL_LOW:
            begin
                mul_a = MUL_A_W'(band_reg);
                mul_b = f1_ext;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ssvbp_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // phase to quarter-wave table index
    assign phase    = mul_prod[PHASE_LSB +: PHASE_W];
    assign pos_raw  = {1'b0, phase[PHASE_W-3:0]};
    assign pos      = phase[PHASE_W-2] ? (POS_W'(1) << (PHASE_W - 2)) - pos_raw : pos_raw;
    assign idx_prod = IDX_PROD_W'(pos) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign rom_addr = idx_prod[POS_W-1 +: ADDR_W];

    ssvbp_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // tuning coefficient, twice the sine, negative in the second half turn
    assign f1_twice = $signed({1'b0, rom_data, 1'b0});

    // filter arithmetic
    assign x_val     = ST_W'(mono_reg) <<< STATE_FRAC_BITS;
    assign damp_term = WIDE_W'(mul_prod >>> DAMP_SHIFT);
    assign tune_term = WIDE_W'(mul_prod >>> TUNE_SHIFT);
    assign hp_wide   = WIDE_W'(x_val) - WIDE_W'(low_reg) - damp_term;
    assign band_wide = WIDE_W'(band_reg) + tune_term;
    assign low_wide  = WIDE_W'(low_reg) + tune_term;

    // wet output, saturated to the sample width
    assign wet_shift = band_reg >>> STATE_FRAC_BITS;
    assign wet = (wet_shift[ST_W-1:SAMPLE_W-1] != {(ST_W - SAMPLE_W + 1){wet_shift[ST_W-1]}})
               ? {wet_shift[ST_W-1], {(SAMPLE_W - 1){~wet_shift[ST_W-1]}}}
               : wet_shift[SAMPLE_W-1:0];

    always_comb
    begin
        case (sel_reg)
            SEL_DRY: last_next = mono_reg;
            SEL_WET: last_next = wet;
            default: last_next = last_reg;
        endcase
    end

    // sweep and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cf_reg         <= CF_RST;
            sweep_down_reg <= 1'b0;
            band_reg       <= '0;
            low_reg        <= '0;
            last_reg       <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cf_reg         <= cf_clamped;
                sweep_down_reg <= sweep_down_reg ^ above ^ below;
            end
            if (cmd.band_load)
            begin
                band_reg <= sat_state(band_wide);
            end
            if (cmd.low_load)
            begin
                cf_reg         <= cf_swept;
                sweep_down_reg <= sweep_down_reg ^ out_of_range;
                low_reg        <= sat_state(low_wide);
                last_reg       <= last_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mono_reg <= mono_next;
            sel_reg  <= select;
        end
        if (cmd.phase_load)
        begin
            neg_reg <= phase[PHASE_W-1];
        end
        if (cmd.f1_load)
        begin
            f1_reg <= neg_reg ? -f1_twice : f1_twice;
        end
        if (cmd.hp_load)
        begin
            hp_reg <= sat_state(hp_wide);
        end
        if (cmd.out_load)
        begin
            out_reg <= last_reg;
        end
    end

    assign out_sample = out_reg;

endmodule

[rtl/core/ssvbp_ctrl.sv]
// controller: sequences one transaction through the shared multiplier
// owns the input and output handshakes, drives the datapath command struct
// depends on ssvbp_pkg
module ssvbp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ssvbp_pkg::ssvbp_cmd_t cmd
);
    import ssvbp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PH_MUL,
        ST_PH_SUM,
        ST_ROM_RD,
        ST_F1,
        ST_HP,
        ST_BP_MUL,
        ST_BP_SUM,
        ST_BP_UPD,
        ST_LP_MUL,
        ST_LP_SUM,
        ST_LP_UPD,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // output slot: filled when a result finishes, emptied when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == ST_DONE && slot_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // state and output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:   if (accept) state_reg <= ST_PH_MUL;
                ST_PH_MUL: state_reg <= ST_PH_SUM;
                ST_PH_SUM: state_reg <= ST_ROM_RD;
                ST_ROM_RD: state_reg <= ST_F1;
                ST_F1:     state_reg <= ST_HP;
                ST_HP:     state_reg <= ST_BP_MUL;
                ST_BP_MUL: state_reg <= ST_BP_SUM;
                ST_BP_SUM: state_reg <= ST_BP_UPD;
                ST_BP_UPD: state_reg <= ST_LP_MUL;
                ST_LP_MUL: state_reg <= ST_LP_SUM;
                ST_LP_SUM: state_reg <= ST_LP_UPD;
                ST_LP_UPD: state_reg <= ST_DONE;
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb
    begin
        cmd        = '0;
        cmd.accept = accept;
        case (state_reg)
            ST_PH_MUL: cmd.mul_sel    = MUL_PHASE;
            ST_ROM_RD:
            begin
                cmd.phase_load = 1'b1;
                cmd.mul_sel    = MUL_DAMP;
            end
            ST_F1:     cmd.f1_load    = 1'b1;
            ST_HP:     cmd.hp_load    = 1'b1;
            ST_BP_MUL: cmd.mul_sel    = MUL_BAND;
            ST_BP_UPD: cmd.band_load  = 1'b1;
            ST_LP_MUL: cmd.mul_sel    = MUL_LOW;
            ST_LP_UPD: cmd.low_load   = 1'b1;
            ST_DONE:   cmd.out_load   = slot_free;
            default:   ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/swept_state_variable_bandpass_core.sv]
// Swept state-variable band-pass (wah) core. Each transaction takes a stereo pair,
// averages it to mono and runs it through a Chamberlin state-variable filter whose
// centre frequency sweeps as a triangle between the min and max registers; select 1
// returns the dry mono sample, select 2 the saturated band-pass output, and any
// other code repeats the previous output. One transaction is in flight at a time;
// the next is accepted only after the controller has run four products (phase,
// damping, band, low) through one shared two-stage multiplier plus the registered
// sine table read, and after the previous result has a free output slot. A finished
// result waits in the output register while the next transaction is accepted.
// Configuration registers may only be written while no transaction is in flight.
// top level: controller and datapath
// depends on ssvbp_pkg, ssvbp_ctrl and ssvbp_datapath
module swept_state_variable_bandpass_core #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int STATE_FRAC_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic        [ssvbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ssvbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [ssvbp_pkg::SAMPLE_W-1:0]   left_sample,
    input  logic signed [ssvbp_pkg::SAMPLE_W-1:0]   right_sample,
    input  logic        [ssvbp_pkg::SEL_W-1:0]      select,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ssvbp_pkg::SAMPLE_W-1:0]   out_sample
);
    import ssvbp_pkg::*;

    ssvbp_cmd_t cmd;

    // sequencer
    ssvbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // arithmetic and state
    ssvbp_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .STATE_FRAC_BITS  (STATE_FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .select       (select),
        .out_sample   (out_sample)
    );

    // a new transaction is never taken in the cycle after one was accepted
    a_no_double_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("transaction accepted while previous one still in flight");

    // the output register is only reloaded when its result has gone
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("pending output overwritten");

    // the low-pass update always follows the band-pass update of the same transaction
    a_band_before_low: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.low_load |-> $past(cmd.band_load, 3))
        else $error("low-pass state updated out of order");

endmodule
